FILE: src/tsm_pkg.sv
// ----------------------------------------------------------------------------
// tsm_pkg: shared definitions of the timestamp merge
// Codes, widths, reset values and types used by the merge and its checker.
// ----------------------------------------------------------------------------
package tsm_pkg;

   // default lane count and register reset values
   localparam int LANES_DEFAULT = 16;
   localparam logic [15:0] SKEW_RESET   = 16'd180;
   localparam logic [4:0]  ACTIVE_RESET = 5'd16;

   // field widths
   localparam int ACTION_W = 2;
   localparam int LANE_W   = 4;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 3;
   localparam int EMPTY_W  = 5;
   localparam int SKEW_W   = 16;
   localparam int ACTIVE_W = 5;
   localparam int CSR_IDX_W = 4;

   // stream widths
   localparam int REQ_TDATA_W = 104;  // 100 bits of fields padded to bytes
   localparam int RSP_TDATA_W = 144;  // 137 bits of fields padded to bytes
   localparam int RSP_REC_W   = 100;  // out_lane .. out_record_tag

   // actions
   localparam logic [ACTION_W-1:0] ACT_OFFER   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NONE     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_HELD     = 3'd4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SKEW   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE = 4'd1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_APPLY,
      S_SCAN,
      S_DECIDE
   } state_type;

   typedef struct packed {
      logic [WORD_W-1:0] record_tag;
      logic [WORD_W-1:0] server_tag;
      logic [WORD_W-1:0] stamp;
   } head_type;

endpackage

FILE: src/tsm_head_ram.sv
// ----------------------------------------------------------------------------
// tsm_head_ram: lane head record store
// One write port and one registered read port, one entry per lane.
// ----------------------------------------------------------------------------
module tsm_head_ram #(
   parameter int LANES = tsm_pkg::LANES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [((LANES > 1) ? $clog2(LANES) : 1)-1:0] wr_addr,
   input  tsm_pkg::head_type                    wr_data,
   input  logic [((LANES > 1) ? $clog2(LANES) : 1)-1:0] rd_addr,
   output tsm_pkg::head_type                    rd_data
);

   tsm_pkg::head_type mem [LANES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: src/timestamp_merge_with_skew_holdback_top.sv
// ----------------------------------------------------------------------------
// timestamp_merge_with_skew_holdback_top: time-ordered merge of lane heads
// Holds one head record per lane, takes offers and ticks, and releases the
// oldest head unless clock-skew holdback applies.
// ----------------------------------------------------------------------------
// Each request transaction runs through these steps from acceptance to the
// next possible acceptance: apply an offer or tick; scan, reading one lane head
// per cycle through the single read port of the head store and running it
// through one shared compare unit; decide the release once the response
// register is free; and return to idle to take the next transaction. The
// response is registered; a new request is taken while an earlier response
// still waits. Every request gives exactly one response. Write the
// configuration registers only while the block is idle.
// ----------------------------------------------------------------------------
module timestamp_merge_with_skew_holdback_top #(
   parameter int LANES = tsm_pkg::LANES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // lane[3:0], stamp[35:4], server_tag[67:36], record_tag[99:68], zero pad
   input  logic [tsm_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // action[1:0]
   input  logic [tsm_pkg::ACTION_W-1:0]        req_tuser,
   // response stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_lane[3:0], out_stamp[35:4], out_server_tag[67:36],
   // out_record_tag[99:68], now_time[131:100], empty_count[136:132], zero pad
   output logic [tsm_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // status[2:0]
   output logic [tsm_pkg::STATUS_W-1:0]        rsp_tuser,
   // configuration write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tsm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tsm_pkg::SKEW_W-1:0]          csr_data
);

   localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int CNT_W = $clog2(LANES + 1);
   localparam int ACT_W = (CNT_W > tsm_pkg::ACTIVE_W) ? CNT_W : tsm_pkg::ACTIVE_W;
   localparam int W     = tsm_pkg::WORD_W;

   // sequencer and configuration
   tsm_pkg::state_type                 state_ff, state_in;
   logic [tsm_pkg::SKEW_W-1:0]         skew_ff, skew_in;
   logic [tsm_pkg::ACTIVE_W-1:0]       active_ff, active_in;
   logic [W-1:0]                       now_ff, now_in;
   logic [LANES-1:0]                   valid_ff, valid_in;

   // latched request
   logic [tsm_pkg::ACTION_W-1:0]       action_ff, action_in;
   logic [tsm_pkg::LANE_W-1:0]         lane_ff, lane_in;
   tsm_pkg::head_type                  rec_ff, rec_in;
   logic [tsm_pkg::STATUS_W-1:0]       op_status_ff, op_status_in;

   // scan
   logic [CNT_W-1:0]                   issue_ff, issue_in;
   logic                               cmp_v_ff, cmp_v_in;
   logic [IDX_W-1:0]                   cmp_idx_ff, cmp_idx_in;
   logic [CNT_W-1:0]                   empty_ff, empty_in;
   logic                               found_ff, found_in;
   logic [IDX_W-1:0]                   best_idx_ff, best_idx_in;
   tsm_pkg::head_type                  best_ff, best_in;

   // response register
   logic                               rsp_v_ff, rsp_v_in;
   logic [tsm_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [tsm_pkg::LANE_W-1:0]         rsp_lane_ff, rsp_lane_in;
   tsm_pkg::head_type                  rsp_rec_ff, rsp_rec_in;
   logic [W-1:0]                       rsp_now_ff, rsp_now_in;
   logic [tsm_pkg::EMPTY_W-1:0]        rsp_empty_ff, rsp_empty_in;

   // head store ports
   logic                               ram_we;
   logic [IDX_W-1:0]                   ram_waddr;
   logic [IDX_W-1:0]                   ram_raddr;
   tsm_pkg::head_type                  ram_rdata;

   // shared compare and holdback arithmetic
   logic [ACT_W-1:0]                   act_ext, act;
   logic                               lane_ok;
   logic [W-1:0]                       d_newer;
   logic                               older;
   logic [W-1:0]                       d_hold;
   logic                               out_free;

   tsm_head_ram #(
      .LANES (LANES)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (rec_ff),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_tready = (state_ff == tsm_pkg::S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'd0, rsp_empty_ff, rsp_now_ff, rsp_rec_ff.record_tag,
                        rsp_rec_ff.server_tag, rsp_rec_ff.stamp, rsp_lane_ff};

   // clamp the active lane count to the lanes that exist
   assign act_ext = ACT_W'(active_ff);
   assign act     = (act_ext > ACT_W'(LANES)) ? ACT_W'(LANES) : act_ext;
   assign lane_ok = (ACT_W'(lane_ff) < act) && !valid_ff[IDX_W'(lane_ff)];

   // offers move the estimate only forward, judged modulo 2^32
   assign d_newer = rec_ff.stamp - now_ff;
   // candidate ordering: smaller stamp, then smaller server tag, then lower lane
   assign older   = (ram_rdata.stamp < best_ff.stamp) ||
                    ((ram_rdata.stamp == best_ff.stamp) &&
                     (ram_rdata.server_tag < best_ff.server_tag));
   assign d_hold  = now_ff - W'(skew_ff) - best_ff.stamp;
   assign out_free = !rsp_v_ff || rsp_tready;

   assign ram_we    = (state_ff == tsm_pkg::S_APPLY) && (action_ff == tsm_pkg::ACT_OFFER) &&
                      lane_ok;
   assign ram_waddr = IDX_W'(lane_ff);
   assign ram_raddr = issue_ff[IDX_W-1:0];

   always_comb begin
      state_in      = state_ff;
      skew_in       = skew_ff;
      active_in     = active_ff;
      now_in        = now_ff;
      valid_in      = valid_ff;
      action_in     = action_ff;
      lane_in       = lane_ff;
      rec_in        = rec_ff;
      op_status_in  = op_status_ff;
      issue_in      = issue_ff;
      cmp_v_in      = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      empty_in      = empty_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      rsp_v_in      = rsp_v_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_lane_in   = rsp_lane_ff;
      rsp_rec_in    = rsp_rec_ff;
      rsp_now_in    = rsp_now_ff;
      rsp_empty_in  = rsp_empty_ff;

      if (csr_valid) begin
         unique case (csr_index)
            tsm_pkg::CSR_SKEW:   skew_in   = csr_data;
            tsm_pkg::CSR_ACTIVE: active_in = csr_data[tsm_pkg::ACTIVE_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         tsm_pkg::S_IDLE: begin
            if (req_tvalid) begin
               action_in         = req_tuser;
               lane_in           = req_tdata[3:0];
               rec_in.stamp      = req_tdata[35:4];
               rec_in.server_tag = req_tdata[67:36];
               rec_in.record_tag = req_tdata[99:68];
               state_in          = tsm_pkg::S_APPLY;
            end
         end
         tsm_pkg::S_APPLY: begin
            // apply offer or tick, then prepare the scan
            op_status_in = tsm_pkg::ST_REJECTED;
            unique case (action_ff)
               tsm_pkg::ACT_OFFER: begin
                  if (lane_ok) begin
                     valid_in[IDX_W'(lane_ff)] = 1'b1;
                     if ((d_newer != '0) && !d_newer[W-1]) begin
                        now_in = rec_ff.stamp;
                     end
                     op_status_in = tsm_pkg::ST_ACCEPTED;
                  end
               end
               tsm_pkg::ACT_TICK: begin
                  now_in       = now_ff + W'(1);
                  op_status_in = tsm_pkg::ST_ACCEPTED;
               end
               default: ;
            endcase
            issue_in = '0;
            empty_in = '0;
            found_in = 1'b0;
            state_in = tsm_pkg::S_SCAN;
         end
         tsm_pkg::S_SCAN: begin
            // issue one read per cycle; compare the entry read last cycle
            if (issue_ff != CNT_W'(LANES)) begin
               cmp_v_in   = 1'b1;
               cmp_idx_in = issue_ff[IDX_W-1:0];
               issue_in   = issue_ff + CNT_W'(1);
            end else begin
               state_in = tsm_pkg::S_DECIDE;
            end
            if (cmp_v_ff && (ACT_W'(cmp_idx_ff) < act)) begin
               if (!valid_ff[cmp_idx_ff]) begin
                  empty_in = empty_ff + CNT_W'(1);
               end else if (!found_ff || older) begin
                  found_in    = 1'b1;
                  best_idx_in = cmp_idx_ff;
                  best_in     = ram_rdata;
               end
            end
         end
         tsm_pkg::S_DECIDE: begin
            // wait for the response register to free up, then post the result
            if (out_free) begin
               rsp_v_in      = 1'b1;
               rsp_lane_in   = '0;
               rsp_rec_in    = '0;
               rsp_now_in    = now_ff;
               rsp_empty_in  = tsm_pkg::EMPTY_W'(empty_ff);
               rsp_status_in = op_status_ff;
               if (action_ff == tsm_pkg::ACT_RELEASE) begin
                  priority if (!found_ff) begin
                     rsp_status_in = tsm_pkg::ST_NONE;
                  end else if ((empty_ff != '0) && d_hold[W-1]) begin
                     rsp_status_in = tsm_pkg::ST_HELD;
                  end else begin
                     rsp_status_in         = tsm_pkg::ST_RELEASED;
                     rsp_lane_in           = tsm_pkg::LANE_W'(best_idx_ff);
                     rsp_rec_in            = best_ff;
                     rsp_empty_in          = tsm_pkg::EMPTY_W'(empty_ff + CNT_W'(1));
                     valid_in[best_idx_ff] = 1'b0;
                  end
               end
               state_in = tsm_pkg::S_IDLE;
            end
         end
         default: state_in = tsm_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= tsm_pkg::S_IDLE;
         skew_ff   <= tsm_pkg::SKEW_RESET;
         active_ff <= tsm_pkg::ACTIVE_RESET;
         now_ff    <= '0;
         valid_ff  <= '0;
         rsp_v_ff  <= 1'b0;
         cmp_v_ff  <= 1'b0;
         issue_ff  <= '0;
         empty_ff  <= '0;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         skew_ff   <= skew_in;
         active_ff <= active_in;
         now_ff    <= now_in;
         valid_ff  <= valid_in;
         rsp_v_ff  <= rsp_v_in;
         cmp_v_ff  <= cmp_v_in;
         issue_ff  <= issue_in;
         empty_ff  <= empty_in;
         found_ff  <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      lane_ff       <= lane_in;
      rec_ff        <= rec_in;
      op_status_ff  <= op_status_in;
      cmp_idx_ff    <= cmp_idx_in;
      best_idx_ff   <= best_idx_in;
      best_ff       <= best_in;
      rsp_status_ff <= rsp_status_in;
      rsp_lane_ff   <= rsp_lane_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_now_ff    <= rsp_now_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

endmodule

FILE: src/tsm_checker.sv
// ----------------------------------------------------------------------------
// tsm_checker: port-level checks of the timestamp merge
// Watches the top level's ports and reports rule breaks; bound to the top.
// ----------------------------------------------------------------------------
module tsm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [tsm_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic [tsm_pkg::STATUS_W-1:0]     rsp_tuser
);

   // a stalled response keeps its valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // a stalled response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response payload changed while stalled");

   // one transaction at a time: ready drops right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // record fields carry data only for a release
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != tsm_pkg::ST_RELEASED) |->
         (rsp_tdata[tsm_pkg::RSP_REC_W-1:0] == '0))
      else $error("record fields set on a non-release response");

endmodule

bind timestamp_merge_with_skew_holdback_top tsm_checker u_tsm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
